### rtl/tpsg_pkg.sv
// shared constants, register map and sine table builder for the three-phase sine pwm block
package tpsg_pkg;

	localparam int SINE_DEPTH_DEF = 1024;
	localparam int PHASE_BITS_DEF = 24;
	localparam int DUTY_BITS_DEF  = 16;

	localparam int STEP_W     = 24;
	localparam int AMP_W      = 16;
	localparam int PERIOD_W   = 16;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AMP    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd3;

	localparam logic [STEP_W-1:0]   STEP_RST   = 24'd2670;
	localparam logic [AMP_W-1:0]    AMP_RST    = 16'd8192;
	localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd4249;

	// serial multiplier: 18-bit signed multiplicand, 16-bit unsigned multiplier
	localparam int SAMPLE_W = 16;
	localparam int MC_W     = 18;
	localparam int MUL_BITS = 16;
	localparam int PROD_W   = MC_W + MUL_BITS;
	localparam int W_BITS   = 17;

	localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// one table entry, quarter-wave polynomial in q2.30, lq = log2 of a quarter wave
	function automatic logic signed [SAMPLE_W-1:0] sine_sample(input int unsigned idx,
			input int unsigned lq);
		logic [63:0] q;
		logic [63:0] quad;
		logic [63:0] r;
		logic [63:0] m;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] v;
		q    = 64'd1 << lq;
		quad = 64'(idx) >> lq;
		r    = 64'(idx) & (q - 64'd1);
		m    = quad[0] ? (q - r) : r;
		x    = (HALF_PI_Q30 * m) >> lq;
		x2   = (x * x) >> 30;
		t    = Q30_ONE;
		t    = Q30_ONE - (((x2 * t) >> 30) / 110);
		t    = Q30_ONE - (((x2 * t) >> 30) / 72);
		t    = Q30_ONE - (((x2 * t) >> 30) / 42);
		t    = Q30_ONE - (((x2 * t) >> 30) / 20);
		t    = Q30_ONE - (((x2 * t) >> 30) / 6);
		s    = (x * t) >> 30;
		v    = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return quad[1] ? -signed'(v[SAMPLE_W-1:0]) : signed'(v[SAMPLE_W-1:0]);
	endfunction

endpackage

### rtl/three_phase_sine_pwm_generator.sv
// Three-phase open-loop sine pwm generator. Each accepted word with period_tick set yields one
// result word: with motor_enable set the phase accumulator advances by phase_step and the three
// duties come from the sine table at the phase, +1/3 and +2/3 revolution, scaled by amplitude
// and mapped onto 0..pwm_period; with motor_enable clear the phase holds and all duties are
// pwm_period/2. A word with period_tick clear is taken and dropped. The input is not ready
// while a tick is in progress. For an enabled tick, a bit-serial divide by three forms the
// shifted table indices, then one shift-and-add multiplier runs six times (scale and map for
// each phase) behind a one-port table read. The result waits in an output register, so the
// next tick is taken while the previous result is not yet read.
module three_phase_sine_pwm_generator import tpsg_pkg::*; #(
	parameter int SINE_DEPTH = SINE_DEPTH_DEF,
	parameter int PHASE_BITS = PHASE_BITS_DEF,
	parameter int DUTY_BITS  = DUTY_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  period_tick,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DUTY_BITS-1:0]  duty_a,
	output logic [DUTY_BITS-1:0]  duty_b,
	output logic [DUTY_BITS-1:0]  duty_c,
	output logic [PHASE_BITS-1:0] electrical_phase,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int LD    = $clog2(SINE_DEPTH);
	localparam int SHIFT = PHASE_BITS - LD;
	localparam int SW    = PHASE_BITS + 3;
	localparam int UW    = LD + 3;
	localparam int ITER  = (UW > MUL_BITS) ? UW : MUL_BITS;
	localparam int CNT_W = $clog2(ITER);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_LOAD  = 4'd1;
	localparam logic [3:0] ST_DIV   = 4'd2;
	localparam logic [3:0] ST_ROM   = 4'd3;
	localparam logic [3:0] ST_MUL1  = 4'd4;
	localparam logic [3:0] ST_CLAMP = 4'd5;
	localparam logic [3:0] ST_MUL2  = 4'd6;
	localparam logic [3:0] ST_STORE = 4'd7;
	localparam logic [3:0] ST_DONE  = 4'd8;

	localparam logic [1:0] LANE_A = 2'd0;
	localparam logic [1:0] LANE_B = 2'd1;
	localparam logic [1:0] LANE_C = 2'd2;

	localparam logic [W_BITS-1:0] W_FULL = W_BITS'(65536);

	// sine table, constant at elaboration
	logic signed [SAMPLE_W-1:0] sine_rom [SINE_DEPTH];
	for (genvar g = 0; g < SINE_DEPTH; g++) begin : g_rom
		assign sine_rom[g] = sine_sample(g, LD - 2);
	end

	logic                  enable_q;
	logic [STEP_W-1:0]     step_q;
	logic [AMP_W-1:0]      amp_q;
	logic [PERIOD_W-1:0]   period_q;
	logic [PHASE_BITS-1:0] phase_q;
	logic [3:0]            state_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [1:0]            lane_q;

	logic [UW-1:0]         ub_q;
	logic [UW-1:0]         uc_q;
	logic [1:0]            rb_q;
	logic [1:0]            rc_q;
	logic [LD-1:0]         qb_q;
	logic [LD-1:0]         qc_q;

	logic signed [MC_W-1:0] mcand_q;
	logic [MUL_BITS-1:0]    mplier_q;
	logic [PROD_W-1:0]      prod_q;

	logic [DUTY_BITS-1:0]  res_a_q;
	logic [DUTY_BITS-1:0]  res_b_q;
	logic [DUTY_BITS-1:0]  res_c_q;
	logic                  out_valid_q;
	logic [DUTY_BITS-1:0]  duty_a_q;
	logic [DUTY_BITS-1:0]  duty_b_q;
	logic [DUTY_BITS-1:0]  duty_c_q;
	logic [PHASE_BITS-1:0] phase_out_q;

	logic                  in_acc;
	logic signed [31:0]    step_sx;
	logic [PHASE_BITS-1:0] step_pb;
	logic [SW-1:0]         tri_ph;
	logic [SW-1:0]         sum_b;
	logic [SW-1:0]         sum_c;
	logic [2:0]            rb2;
	logic [2:0]            rc2;
	logic                  qbit_b;
	logic                  qbit_c;
	logic [LD-1:0]         rom_addr;
	logic signed [MC_W-1:0] hi;
	logic signed [MC_W-1:0] addend;
	logic signed [MC_W:0]   mac_sum;
	logic signed [19:0]    wt;
	logic [W_BITS-1:0]     w_clamp;
	logic [PERIOD_W-1:0]   half_period;
	logic                  out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	assign out_valid        = out_valid_q;
	assign duty_a           = duty_a_q;
	assign duty_b           = duty_b_q;
	assign duty_c           = duty_c_q;
	assign electrical_phase = phase_out_q;

	assign step_sx = 32'(signed'(step_q));
	assign step_pb = step_sx[PHASE_BITS-1:0];

	// 3*phase + k*2^PHASE_BITS, scaled down to table units
	assign tri_ph = SW'(phase_q) + (SW'(phase_q) << 1);
	assign sum_b  = tri_ph + (SW'(1) << PHASE_BITS);
	assign sum_c  = tri_ph + (SW'(2) << PHASE_BITS);

	// restoring divide by three, one bit per cycle
	assign rb2    = {rb_q, ub_q[UW-1]};
	assign rc2    = {rc_q, uc_q[UW-1]};
	assign qbit_b = (rb2 >= 3'd3);
	assign qbit_c = (rc2 >= 3'd3);

	always_comb begin
		unique case (lane_q)
			LANE_A:  rom_addr = phase_q[PHASE_BITS-1 -: LD];
			LANE_B:  rom_addr = qb_q;
			LANE_C:  rom_addr = qc_q;
			default: rom_addr = phase_q[PHASE_BITS-1 -: LD];
		endcase
	end

	// shift-and-add step: add into the high half, then shift right
	assign hi      = signed'(prod_q[PROD_W-1:MUL_BITS]);
	assign addend  = mplier_q[0] ? mcand_q : '0;
	assign mac_sum = (MC_W+1)'(hi) + (MC_W+1)'(addend);

	// floor(p / 2^15) + 32768, held to 0..65536
	assign wt = 20'(signed'(prod_q[PROD_W-1:15])) + 20'sd32768;
	always_comb begin
		if (wt[19]) begin
			w_clamp = '0;
		end else if (wt > 20'sd65536) begin
			w_clamp = W_FULL;
		end else begin
			w_clamp = wt[W_BITS-1:0];
		end
	end

	assign half_period = period_q >> 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			step_q   <= STEP_RST;
			amp_q    <= AMP_RST;
			period_q <= PERIOD_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ENABLE: enable_q <= cfg_data[0];
				REG_STEP:   step_q   <= cfg_data[STEP_W-1:0];
				REG_AMP:    amp_q    <= cfg_data[AMP_W-1:0];
				REG_PERIOD: period_q <= cfg_data[PERIOD_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= '0;
			cnt_q       <= '0;
			lane_q      <= LANE_A;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && period_tick) begin
						if (enable_q) begin
							phase_q <= phase_q + step_pb;
							state_q <= ST_LOAD;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_LOAD: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(UW - 1)) begin
						lane_q  <= LANE_A;
						state_q <= ST_ROM;
					end
				end
				ST_ROM: begin
					cnt_q   <= '0;
					state_q <= ST_MUL1;
				end
				ST_MUL1: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(MUL_BITS - 1)) begin
						state_q <= ST_CLAMP;
					end
				end
				ST_CLAMP: begin
					cnt_q   <= '0;
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(MUL_BITS - 1)) begin
						state_q <= ST_STORE;
					end
				end
				ST_STORE: begin
					if (lane_q == LANE_C) begin
						state_q <= ST_DONE;
					end else begin
						lane_q  <= lane_q + 1'b1;
						state_q <= ST_ROM;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && period_tick && !enable_q) begin
					res_a_q <= half_period[DUTY_BITS-1:0];
					res_b_q <= half_period[DUTY_BITS-1:0];
					res_c_q <= half_period[DUTY_BITS-1:0];
				end
			end
			ST_LOAD: begin
				ub_q <= sum_b[SW-1:SHIFT];
				uc_q <= sum_c[SW-1:SHIFT];
				rb_q <= '0;
				rc_q <= '0;
			end
			ST_DIV: begin
				ub_q <= ub_q << 1;
				uc_q <= uc_q << 1;
				rb_q <= qbit_b ? 2'(rb2 - 3'd3) : rb2[1:0];
				rc_q <= qbit_c ? 2'(rc2 - 3'd3) : rc2[1:0];
				qb_q <= {qb_q[LD-2:0], qbit_b};
				qc_q <= {qc_q[LD-2:0], qbit_c};
			end
			ST_ROM: begin
				mcand_q  <= MC_W'(sine_rom[rom_addr]);
				mplier_q <= amp_q;
				prod_q   <= '0;
			end
			ST_MUL1, ST_MUL2: begin
				prod_q   <= {mac_sum, prod_q[MUL_BITS-1:1]};
				mplier_q <= mplier_q >> 1;
			end
			ST_CLAMP: begin
				mcand_q  <= signed'({1'b0, w_clamp});
				mplier_q <= period_q;
				prod_q   <= '0;
			end
			ST_STORE: begin
				unique case (lane_q)
					LANE_A:  res_a_q <= prod_q[MUL_BITS +: DUTY_BITS];
					LANE_B:  res_b_q <= prod_q[MUL_BITS +: DUTY_BITS];
					LANE_C:  res_c_q <= prod_q[MUL_BITS +: DUTY_BITS];
					default: res_a_q <= prod_q[MUL_BITS +: DUTY_BITS];
				endcase
			end
			ST_DONE: begin
				if (out_free) begin
					duty_a_q    <= res_a_q;
					duty_b_q    <= res_b_q;
					duty_c_q    <= res_c_q;
					phase_out_q <= phase_q;
				end
			end
			default: ;
		endcase
	end

endmodule

### rtl/tpsg_checker.sv
// port-level checks for the three-phase sine pwm block, bound to its top level
module tpsg_checker import tpsg_pkg::*; #(
	parameter int PHASE_BITS = PHASE_BITS_DEF,
	parameter int DUTY_BITS  = DUTY_BITS_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  period_tick,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [DUTY_BITS-1:0]  duty_a,
	input logic [DUTY_BITS-1:0]  duty_b,
	input logic [DUTY_BITS-1:0]  duty_c,
	input logic [PHASE_BITS-1:0] electrical_phase
);

	// a waiting result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(duty_a) && $stable(duty_b)
			&& $stable(duty_c) && $stable(electrical_phase))
		else $error("result word changed while stalled");

	// a real tick occupies the engine
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && period_tick |=> !in_ready)
		else $error("input still ready after a tick was taken");

	// a word without a tick is dropped
	a_no_tick_no_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !period_tick |=> !$rose(out_valid))
		else $error("result word after a word without tick");

	// a result only appears at the end of a busy stretch
	a_word_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result word appeared while idle");

endmodule

bind three_phase_sine_pwm_generator tpsg_checker #(
	.PHASE_BITS(PHASE_BITS),
	.DUTY_BITS(DUTY_BITS)
) u_tpsg_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.period_tick(period_tick),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.duty_a(duty_a),
	.duty_b(duty_b),
	.duty_c(duty_c),
	.electrical_phase(electrical_phase)
);

### test/tb_top.sv
// self-checking testbench for the three-phase sine pwm generator
`timescale 1ns / 1ps

module tb_top;
	import tpsg_pkg::*;

	localparam int ITEMS       = 1700;
	localparam int SETTLE      = 160;
	localparam int HOLD_CYCLES = 1500;
	localparam int IDLE_LIMIT  = 20000;
	localparam int REPORT_MAX  = 100;
	localparam int TAB_DEPTH   = SINE_DEPTH_DEF;
	localparam int PH_W        = PHASE_BITS_DEF;
	localparam int DU_W        = DUTY_BITS_DEF;

	typedef struct packed {
		logic [DU_W-1:0] a;
		logic [DU_W-1:0] b;
		logic [DU_W-1:0] c;
		logic [PH_W-1:0] ph;
	} pwm_word_t;

	typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

	// for tick rows data[0] is the period_tick value
	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic                  typed;
		pwm_word_t             want;
	} row_t;

	localparam pwm_word_t NO_WANT = '0;
	localparam int N_ROWS = 29;
	localparam row_t DIRECTED [N_ROWS] = '{
		'{ROW_TICK, REG_ENABLE, 24'h000000, 1'b0, NO_WANT},
		'{ROW_TICK, REG_ENABLE, 24'h000001, 1'b1, '{16'd2124, 16'd2124, 16'd2124, 24'd0}},
		'{ROW_CFG,  REG_ENABLE, 24'hFFFFFE, 1'b0, NO_WANT},
		'{ROW_TICK, REG_ENABLE, 24'h000001, 1'b1, '{16'd2124, 16'd2124, 16'd2124, 24'd0}},
		'{ROW_CFG,  REG_PERIOD, 24'hFF0000, 1'b0, NO_WANT},
		'{ROW_CFG,  REG_ENABLE, 24'h000001, 1'b0, NO_WANT},
		'{ROW_TICK, REG_ENABLE, 24'h000001, 1'b1, '{16'd0, 16'd0, 16'd0, 24'd2670}},
		'{ROW_CFG,  REG_PERIOD, 24'hFFFFFF, 1'b0, NO_WANT},
		'{ROW_CFG,  REG_AMP,    24'hFF0000, 1'b0, NO_WANT},
		'{ROW_TICK, REG_ENABLE, 24'h000001, 1'b1, '{16'd32767, 16'd32767, 16'd32767, 24'd5340}},
		'{ROW_CFG,  REG_AMP,    24'h00FFFF, 1'b0, NO_WANT},
		'{ROW_CFG,  REG_STEP,   24'h400000, 1'b0, NO_WANT},
		'{ROW_TICK, REG_ENABLE, 24'h000001, 1'b0, NO_WANT},
		'{ROW_TICK, REG_ENABLE, 24'h000001, 1'b0, NO_WANT},
		'{ROW_CFG,  REG_AMP,    24'h008000, 1'b0, NO_WANT},
		'{ROW_CFG,  REG_STEP,   24'hFFFFFF, 1'b0, NO_WANT},
		'{ROW_TICK, REG_ENABLE, 24'h000001, 1'b0, NO_WANT},
		'{ROW_TICK, REG_ENABLE, 24'h000001, 1'b0, NO_WANT},
		'{ROW_CFG,  REG_STEP,   24'h800000, 1'b0, NO_WANT},
		'{ROW_TICK, REG_ENABLE, 24'h000001, 1'b0, NO_WANT},
		'{ROW_TICK, REG_ENABLE, 24'h000001, 1'b0, NO_WANT},
		'{ROW_CFG,  REG_STEP,   24'h7FFFFF, 1'b0, NO_WANT},
		'{ROW_TICK, REG_ENABLE, 24'h000001, 1'b0, NO_WANT},
		'{ROW_CFG,  REG_PERIOD, 24'h000001, 1'b0, NO_WANT},
		'{ROW_TICK, REG_ENABLE, 24'h000001, 1'b0, NO_WANT},
		'{ROW_CFG,  REG_ENABLE, 24'h000000, 1'b0, NO_WANT},
		'{ROW_TICK, REG_ENABLE, 24'h000001, 1'b0, NO_WANT},
		'{ROW_TICK, REG_ENABLE, 24'h000001, 1'b0, NO_WANT},
		'{ROW_TICK, REG_ENABLE, 24'h000000, 1'b0, NO_WANT}
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic                  period_tick;
	logic                  out_valid;
	logic                  out_ready;
	logic [DU_W-1:0]       duty_a;
	logic [DU_W-1:0]       duty_b;
	logic [DU_W-1:0]       duty_c;
	logic [PH_W-1:0]       electrical_phase;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// predictor state
	logic signed [15:0]  sine_tab [TAB_DEPTH];
	logic [PH_W-1:0]     phase_acc;
	logic                cfg_enable;
	logic [STEP_W-1:0]   cfg_step;
	logic [AMP_W-1:0]    cfg_amp;
	logic [PERIOD_W-1:0] cfg_period;

	pwm_word_t pending_duties [$];
	logic      busy;
	logic      hold_req;
	int        ticks_sent;
	int        enabled_ticks;
	int        noise_sent;
	int        cfg_writes;
	int        results_checked;
	int        mismatches;
	int        idle_cycles;

	three_phase_sine_pwm_generator dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.period_tick      (period_tick),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.duty_a           (duty_a),
		.duty_b           (duty_b),
		.duty_c           (duty_c),
		.electrical_phase (electrical_phase),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always #5 clk = ~clk;

	// quarter-wave polynomial in q2.30, mirrored and negated per quadrant
	function automatic logic signed [15:0] sine_entry(int i);
		longint unsigned qw;
		longint unsigned quad;
		longint unsigned r;
		longint unsigned m;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned s;
		longint unsigned v;
		longint unsigned divs [5];
		logic signed [15:0] smp;
		divs = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
		qw   = 64'(TAB_DEPTH / 4);
		quad = 64'(i) / qw;
		r    = 64'(i) % qw;
		m    = (quad & 64'd1) != 0 ? qw - r : r;
		x    = (HALF_PI_Q30 * m) / qw;
		x2   = (x * x) >> 30;
		t    = Q30_ONE;
		for (int k = 0; k < 5; k++) begin
			t = Q30_ONE - ((x2 * t) >> 30) / divs[k];
		end
		s = (x * t) >> 30;
		v = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		smp = v[15:0];
		return (quad & 64'd2) != 0 ? -smp : smp;
	endfunction

	function automatic logic [DU_W-1:0] scale_duty(logic signed [15:0] smp);
		longint p;
		longint w;
		longint unsigned d;
		p = longint'(cfg_amp) * longint'(smp);
		w = (p >>> 15) + 64'sd32768;
		if (w < 0) begin
			w = 0;
		end
		if (w > 65536) begin
			w = 65536;
		end
		d = (64'(w) * 64'(cfg_period)) >> 16;
		return d[DU_W-1:0];
	endfunction

	function automatic pwm_word_t predict_tick();
		longint unsigned n;
		longint unsigned rev;
		longint unsigned ia;
		longint unsigned ib;
		longint unsigned ic;
		pwm_word_t w;
		if (cfg_enable) begin
			phase_acc = phase_acc + cfg_step;
			rev = 64'd1 << PH_W;
			n   = 64'(phase_acc) * 64'(TAB_DEPTH);
			ia  = (n >> PH_W) % 64'(TAB_DEPTH);
			ib  = ((3 * n + 64'(TAB_DEPTH) * rev) / (3 * rev)) % 64'(TAB_DEPTH);
			ic  = ((3 * n + 2 * 64'(TAB_DEPTH) * rev) / (3 * rev)) % 64'(TAB_DEPTH);
			w.a = scale_duty(sine_tab[ia]);
			w.b = scale_duty(sine_tab[ib]);
			w.c = scale_duty(sine_tab[ic]);
			enabled_ticks++;
		end else begin
			w.a = cfg_period >> 1;
			w.b = w.a;
			w.c = w.a;
		end
		w.ph = phase_acc;
		return w;
	endfunction

	function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		case (idx)
			REG_ENABLE: cfg_enable = d[0];
			REG_STEP:   cfg_step   = d[STEP_W-1:0];
			REG_AMP:    cfg_amp    = d[AMP_W-1:0];
			REG_PERIOD: cfg_period = d[PERIOD_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			return 0;
		end else if (r < 95) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(20, 60);
	endfunction

	// upper data bits stay random, the register keeps only its own width
	function automatic logic [CFG_DATA_W-1:0] rand_reg_value(logic [CFG_IDX_W-1:0] idx);
		logic [CFG_DATA_W-1:0] d;
		d = CFG_DATA_W'($urandom);
		case (idx)
			REG_ENABLE: d[0] = ($urandom_range(0, 9) < 8);
			REG_STEP: begin
				case ($urandom_range(0, 7))
					0: begin
						d = 24'($urandom_range(0, 5000));
						if ($urandom_range(0, 1)) begin
							d = -d;
						end
					end
					1: begin
						case ($urandom_range(0, 5))
							0: d = 24'h000000;
							1: d = 24'h000001;
							2: d = 24'hFFFFFF;
							3: d = 24'h800000;
							4: d = 24'h7FFFFF;
							default: d = 24'h400000;
						endcase
					end
					default: ;
				endcase
			end
			REG_AMP: begin
				case ($urandom_range(0, 5))
					0: begin
						case ($urandom_range(0, 4))
							0: d[15:0] = 16'd0;
							1: d[15:0] = 16'd1;
							2: d[15:0] = 16'd32767;
							3: d[15:0] = 16'd32768;
							default: d[15:0] = 16'd65535;
						endcase
					end
					1: d[15:0] = 16'($urandom_range(32769, 65535));
					default: d[15:0] = 16'($urandom_range(0, 32768));
				endcase
			end
			REG_PERIOD: begin
				case ($urandom_range(0, 5))
					0: begin
						case ($urandom_range(0, 3))
							0: d[15:0] = 16'd0;
							1: d[15:0] = 16'd1;
							2: d[15:0] = 16'd2;
							default: d[15:0] = 16'd65535;
						endcase
					end
					1: d[15:0] = 16'($urandom_range(1, 255));
					default: d[15:0] = 16'($urandom_range(1, 65535));
				endcase
			end
			default: ;
		endcase
		return d;
	endfunction

	task automatic send_tick(logic t, int gap, logic typed, pwm_word_t want);
		pwm_word_t w;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    = 1'b1;
		period_tick = t;
		do @(posedge clk); while (!in_ready);
		if (t) begin
			w = predict_tick();
			pending_duties.push_back(typed ? want : w);
			ticks_sent++;
		end else begin
			noise_sent++;
		end
		busy = 1'b1;
		@(negedge clk);
	endtask

	// registers change only with the block drained and quiet
	task automatic wait_idle();
		in_valid = 1'b0;
		if (busy) begin
			while (pending_duties.size() != 0) @(negedge clk);
			repeat (SETTLE) @(negedge clk);
			busy = 1'b0;
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = d;
		do @(posedge clk); while (!cfg_ready);
		apply_cfg(idx, d);
		cfg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic check_word(pwm_word_t got);
		pwm_word_t want;
		if (pending_duties.size() == 0) begin
			mismatches++;
			if (mismatches <= REPORT_MAX) begin
				$error("result word with nothing expected: a=%0d b=%0d c=%0d phase=%0d",
					got.a, got.b, got.c, got.ph);
			end
		end else begin
			want = pending_duties.pop_front();
			results_checked++;
			if (got != want) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					if (got.a != want.a)
						$error("duty_a: expected %0d, got %0d", want.a, got.a);
					if (got.b != want.b)
						$error("duty_b: expected %0d, got %0d", want.b, got.b);
					if (got.c != want.c)
						$error("duty_c: expected %0d, got %0d", want.c, got.c);
					if (got.ph != want.ph)
						$error("electrical_phase: expected %0d, got %0d", want.ph, got.ph);
				end
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			check_word('{duty_a, duty_b, duty_c, electrical_phase});
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == IDLE_LIMIT) begin
				$display("timeout after %0d cycles without a handshake", IDLE_LIMIT);
				$display("FAILURE");
				$finish;
			end
		end
	end

	// result side: random stalls, free-running stretches and one long hold-off
	initial begin
		int stall_left;
		int mode_left;
		logic free_run;
		stall_left = 0;
		mode_left  = 0;
		free_run   = 1'b0;
		out_ready  = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				if (mode_left == 0) begin
					free_run  = ($urandom_range(0, 3) == 0);
					mode_left = $urandom_range(50, 300);
				end else begin
					mode_left--;
				end
				if (free_run) begin
					out_ready = 1'b1;
				end else if (stall_left > 0) begin
					out_ready = 1'b0;
					stall_left--;
				end else begin
					stall_left = pick_gap();
					out_ready  = (stall_left == 0);
					if (stall_left > 0) begin
						stall_left--;
					end
				end
			end
		end
	end

	initial begin
		int phase_no;
		int burst;
		int nwr;
		logic free_run;
		logic t;
		logic [CFG_IDX_W-1:0] ridx;
		for (int i = 0; i < TAB_DEPTH; i++) begin
			sine_tab[i] = sine_entry(i);
		end
		phase_acc       = '0;
		cfg_enable      = 1'b0;
		cfg_step        = STEP_RST;
		cfg_amp         = AMP_RST;
		cfg_period      = PERIOD_RST;
		busy            = 1'b0;
		hold_req        = 1'b0;
		ticks_sent      = 0;
		enabled_ticks   = 0;
		noise_sent      = 0;
		cfg_writes      = 0;
		results_checked = 0;
		mismatches      = 0;
		idle_cycles     = 0;
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		period_tick     = 1'b0;
		cfg_valid       = 1'b0;
		cfg_index       = REG_ENABLE;
		cfg_data        = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int r = 0; r < N_ROWS; r++) begin
			if (DIRECTED[r].kind == ROW_CFG) begin
				wait_idle();
				write_reg(DIRECTED[r].idx, DIRECTED[r].data);
			end else begin
				send_tick(DIRECTED[r].data[0], pick_gap(), DIRECTED[r].typed, DIRECTED[r].want);
			end
		end

		phase_no = 0;
		while (ticks_sent < ITEMS) begin
			wait_idle();
			if ($urandom_range(0, 9) < 3) begin
				write_reg(REG_ENABLE, rand_reg_value(REG_ENABLE));
				write_reg(REG_STEP, rand_reg_value(REG_STEP));
				write_reg(REG_AMP, rand_reg_value(REG_AMP));
				write_reg(REG_PERIOD, rand_reg_value(REG_PERIOD));
			end else begin
				nwr = $urandom_range(1, 2);
				for (int k = 0; k < nwr; k++) begin
					write_reg(REG_ENABLE, rand_reg_value(REG_ENABLE));
					ridx = CFG_IDX_W'($urandom_range(1, 3));
					write_reg(ridx, rand_reg_value(ridx));
				end
			end
			burst    = $urandom_range(10, 60);
			free_run = ($urandom_range(0, 3) == 0);
			if (phase_no == 2) begin
				// receiver holds off while words keep coming, so the input backs up
				hold_req = 1'b1;
				burst    = 40;
				free_run = 1'b1;
			end
			for (int k = 0; k < burst; k++) begin
				t = ($urandom_range(0, 99) >= 8);
				if ($urandom_range(0, 99) == 0 && pending_duties.size() != 0) begin
					in_valid = 1'b0;
					while (pending_duties.size() != 0) @(negedge clk);
				end
				send_tick(t, free_run ? 0 : pick_gap(), 1'b0, NO_WANT);
			end
			phase_no++;
		end

		in_valid = 1'b0;
		while (pending_duties.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);

		$display("run covered %0d ticks (%0d enabled), %0d dropped words, %0d register writes",
			ticks_sent, enabled_ticks, noise_sent, cfg_writes);
		$display("%0d result words checked, %0d with errors", results_checked, mismatches);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
